>>> hw/rtl/i2c_master_byte_sequencer_defines.svh
// ---------------------------------------------------------------------------
// i2c master byte sequencer assertion macros
// shared helpers for the concurrent checks at the top level
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH

// implication checked every cycle outside reset
`define I2CS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2c sequencer check failed");

// condition that must hold on the cycle after reset is seen
`define I2CS_ASSERT_AFTER_RESET(label, clk, rst, cond) \
   label: assert property (@(posedge clk) (rst) |=> (cond)) \
      else $error("i2c sequencer reset check failed");

`endif

>>> hw/rtl/i2cs_pkg.sv
// ---------------------------------------------------------------------------
// i2cs_pkg
// types, command codes and helpers for the i2c master byte sequencer
// ---------------------------------------------------------------------------
package i2cs_pkg;

   localparam int UNIT_W  = 10;
   localparam int TIMER_W = 11;

   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   localparam logic [UNIT_W-1:0] UNIT_MIN   = 10'd1;
   localparam logic [UNIT_W-1:0] UNIT_RESET = 10'd1;
   localparam logic [7:0]        MSB_MASK   = 8'h80;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] tx_byte;
      logic       send_ack;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_pull_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       slave_acked;
      logic       rejected;
   } rsp_type;

   // timer load for a phase of one or two units: n*u - 1
   function automatic logic [TIMER_W-1:0] timer_load(input logic [UNIT_W-1:0] u,
                                                     input logic two_units);
      logic [UNIT_W-1:0] u_less;
      u_less = u - UNIT_MIN;
      if (two_units) begin
         timer_load = {u_less, 1'b1};
      end else begin
         timer_load = {1'b0, u_less};
      end
   endfunction

endpackage

>>> hw/rtl/i2c_master_byte_sequencer.sv
// path: a word accepted into the input register steps the state/result register, which drives the result port
// throughput: one word per cycle while the result port is not stalled; the engine steps the bus state once per word
// input register and state/result register keep both sides running under stalls
// reset: synchronous, active high; bus released (scl high, sda released),
// phase idle, unit length back to one tick
// ---------------------------------------------------------------------------
// i2c_master_byte_sequencer
// pin-level i2c master: start, stop, byte write with ack sample, byte read
// ---------------------------------------------------------------------------
`include "i2c_master_byte_sequencer_defines.svh"

module i2c_master_byte_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [i2cs_pkg::UNIT_W-1:0] csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [2:0]                  req_cmd,
   input  logic [7:0]                  req_tx_byte,
   input  logic                        req_send_ack,
   input  logic                        req_sda_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_scl_level,
   output logic                        rsp_sda_pull_low,
   output logic                        rsp_busy_res,
   output logic                        rsp_done_res,
   output logic [7:0]                  rsp_rx_byte,
   output logic                        rsp_slave_acked,
   output logic                        rsp_rejected
);
   import i2cs_pkg::*;

   logic [UNIT_W-1:0] unit_ticks_ff;
   req_type           req_word;
   req_type           in_word;
   logic              in_valid;
   logic              take;
   rsp_type           rsp_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= UNIT_RESET;
      end else if (csr_wr_en) begin
         unit_ticks_ff <= csr_wr_data;
      end
   end

   assign req_word.cmd      = req_cmd;
   assign req_word.tx_byte  = req_tx_byte;
   assign req_word.send_ack = req_send_ack;
   assign req_word.sda_in   = req_sda_in;

   i2cs_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .in_valid  (in_valid),
      .in_word   (in_word),
      .take      (take)
   );

   i2cs_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .unit_ticks (unit_ticks_ff),
      .in_valid   (in_valid),
      .in_word    (in_word),
      .take       (take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

   assign rsp_scl_level    = rsp_word.scl_level;
   assign rsp_sda_pull_low = rsp_word.sda_pull_low;
   assign rsp_busy_res     = rsp_word.busy_res;
   assign rsp_done_res     = rsp_word.done_res;
   assign rsp_rx_byte      = rsp_word.rx_byte;
   assign rsp_slave_acked  = rsp_word.slave_acked;
   assign rsp_rejected     = rsp_word.rejected;

   // a finished command always leaves the sequencer idle
   `I2CS_ASSERT_IMPL(a_done_idle, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)
   // a refused command can only come while a sequence was running
   `I2CS_ASSERT_IMPL(a_reject_busy, clock, reset, rsp_valid && rsp_rejected,
                     rsp_busy_res || rsp_done_res)
   // reset empties the pipe and releases the bus
   `I2CS_ASSERT_AFTER_RESET(a_reset_release, clock, reset,
                            !rsp_valid && rsp_scl_level && !rsp_sda_pull_low && !rsp_busy_res)

endmodule

>>> hw/rtl/i2cs_in_stage.sv
// ---------------------------------------------------------------------------
// i2cs_in_stage
// input register: captures one request word and holds it until the
// sequencing engine takes it
// ---------------------------------------------------------------------------
module i2cs_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  i2cs_pkg::req_type req_word,
   output logic             in_valid,
   output i2cs_pkg::req_type in_word,
   input  logic             take
);
   import i2cs_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type word_ff;

   assign req_ready = !valid_ff || take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !take);
   assign in_valid  = valid_ff;
   assign in_word   = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         word_ff <= req_word;
      end
   end

endmodule

>>> hw/rtl/i2cs_engine.sv
// ---------------------------------------------------------------------------
// i2cs_engine
// one tick of the bus sequencer per word: phase machine, bit shifter and
// unit timer; the state registers double as the result register
// ---------------------------------------------------------------------------
module i2cs_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [i2cs_pkg::UNIT_W-1:0]       unit_ticks,
   input  logic                              in_valid,
   input  i2cs_pkg::req_type                 in_word,
   output logic                              take,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output i2cs_pkg::rsp_type                 rsp_word
);
   import i2cs_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE          = 5'd0,
      PH_START_HOLD    = 5'd1,
      PH_START_LOW     = 5'd2,
      PH_STOP_SCL_LOW  = 5'd3,
      PH_STOP_SDA_LOW  = 5'd4,
      PH_STOP_SCL_HIGH = 5'd5,
      PH_WR_SETUP      = 5'd6,
      PH_WR_BIT_LOW    = 5'd7,
      PH_WR_BIT_HIGH   = 5'd8,
      PH_WR_BIT_TAIL   = 5'd9,
      PH_WR_ACK        = 5'd10,
      PH_RD_LOW        = 5'd11,
      PH_RD_HIGH       = 5'd12,
      PH_RD_ACK_SETUP  = 5'd13,
      PH_RD_ACK_DRIVE  = 5'd14,
      PH_RD_ACK_HIGH   = 5'd15,
      PH_RD_ACK_TAIL   = 5'd16
   } phase_type;

   phase_type            phase_ff, phase_in;
   logic [3:0]           bit_count_ff, bit_count_in;
   logic [7:0]           shifter_ff, shifter_in;
   logic [TIMER_W-1:0]   timer_ff, timer_in;
   logic                 scl_ff, scl_in;
   logic                 sda_low_ff, sda_low_in;
   logic                 ack_flag_ff, ack_flag_in;
   logic                 ack_req_ff, ack_req_in;
   logic [7:0]           rx_hold_ff, rx_hold_in;
   logic                 done_ff, done_in;
   logic                 rej_ff, rej_in;
   logic                 rsp_valid_ff;
   logic [UNIT_W-1:0]    u_eff;
   logic [7:0]           shift_next;
   logic [3:0]           count_next;

   assign take      = in_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   assign u_eff = (unit_ticks == '0) ? UNIT_MIN : unit_ticks;

   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shifter_in   = shifter_ff;
      timer_in     = timer_ff;
      scl_in       = scl_ff;
      sda_low_in   = sda_low_ff;
      ack_flag_in  = ack_flag_ff;
      ack_req_in   = ack_req_ff;
      rx_hold_in   = rx_hold_ff;
      done_in      = 1'b0;
      rej_in       = 1'b0;
      count_next   = bit_count_ff + 4'd1;
      shift_next   = {shifter_ff[6:0], 1'b0};

      if (phase_ff != PH_IDLE) begin
         rej_in = (in_word.cmd != CMD_NONE);
         if (timer_ff != '0) begin
            timer_in = timer_ff - 1'b1;
         end else begin
            case (phase_ff)
               PH_START_HOLD: begin
                  phase_in = PH_START_LOW; scl_in = 1'b1; sda_low_in = 1'b1;
                  timer_in = timer_load(u_eff, 1'b1);
               end
               PH_START_LOW: begin
                  phase_in = PH_IDLE; scl_in = 1'b0; sda_low_in = 1'b1;
                  timer_in = '0; done_in = 1'b1;
               end
               PH_STOP_SCL_LOW: begin
                  phase_in = PH_STOP_SDA_LOW; scl_in = 1'b0; sda_low_in = 1'b1;
                  timer_in = timer_load(u_eff, 1'b0);
               end
               PH_STOP_SDA_LOW: begin
                  phase_in = PH_STOP_SCL_HIGH; scl_in = 1'b1; sda_low_in = 1'b1;
                  timer_in = timer_load(u_eff, 1'b0);
               end
               PH_STOP_SCL_HIGH: begin
                  phase_in = PH_IDLE; scl_in = 1'b1; sda_low_in = 1'b0;
                  timer_in = '0; done_in = 1'b1;
               end
               PH_WR_SETUP: begin
                  phase_in   = PH_WR_BIT_LOW; scl_in = 1'b0;
                  sda_low_in = ((shifter_ff & MSB_MASK) == '0);
                  timer_in   = timer_load(u_eff, 1'b0);
               end
               PH_WR_BIT_LOW: begin
                  phase_in = PH_WR_BIT_HIGH; scl_in = 1'b1;
                  timer_in = timer_load(u_eff, 1'b0);
               end
               PH_WR_BIT_HIGH: begin
                  phase_in = PH_WR_BIT_TAIL; scl_in = 1'b0;
                  timer_in = timer_load(u_eff, 1'b0);
               end
               PH_WR_BIT_TAIL: begin
                  shifter_in   = shift_next;
                  bit_count_in = count_next;
                  timer_in     = timer_load(u_eff, 1'b0);
                  if (count_next < 4'd8) begin
                     phase_in   = PH_WR_BIT_LOW; scl_in = 1'b0;
                     sda_low_in = ((shift_next & MSB_MASK) == '0);
                  end else begin
                     phase_in = PH_WR_ACK; scl_in = 1'b1; sda_low_in = 1'b0;
                  end
               end
               PH_WR_ACK: begin
                  ack_flag_in = !in_word.sda_in;
                  phase_in = PH_IDLE; scl_in = 1'b0; sda_low_in = 1'b0;
                  timer_in = '0; done_in = 1'b1;
               end
               PH_RD_LOW: begin
                  phase_in = PH_RD_HIGH; scl_in = 1'b1; sda_low_in = 1'b0;
                  timer_in = timer_load(u_eff, 1'b0);
               end
               PH_RD_HIGH: begin
                  // sample data on the last tick of scl high, as scl is driven low
                  shifter_in   = {shifter_ff[6:0], in_word.sda_in};
                  bit_count_in = count_next;
                  scl_in       = 1'b0;
                  sda_low_in   = 1'b0;
                  timer_in     = timer_load(u_eff, 1'b0);
                  if (count_next < 4'd8) begin
                     phase_in = PH_RD_LOW;
                  end else begin
                     rx_hold_in = {shifter_ff[6:0], in_word.sda_in};
                     phase_in   = PH_RD_ACK_SETUP;
                  end
               end
               PH_RD_ACK_SETUP: begin
                  phase_in = PH_RD_ACK_DRIVE; scl_in = 1'b0; sda_low_in = ack_req_ff;
                  timer_in = timer_load(u_eff, 1'b0);
               end
               PH_RD_ACK_DRIVE: begin
                  phase_in = PH_RD_ACK_HIGH; scl_in = 1'b1; sda_low_in = ack_req_ff;
                  timer_in = timer_load(u_eff, 1'b1);
               end
               PH_RD_ACK_HIGH: begin
                  if (ack_req_ff) begin
                     phase_in = PH_RD_ACK_TAIL; scl_in = 1'b0; sda_low_in = 1'b1;
                     timer_in = timer_load(u_eff, 1'b0);
                  end else begin
                     phase_in = PH_IDLE; scl_in = 1'b1; sda_low_in = 1'b0;
                     timer_in = '0; done_in = 1'b1;
                  end
               end
               PH_RD_ACK_TAIL: begin
                  phase_in = PH_IDLE; scl_in = 1'b0; sda_low_in = 1'b1;
                  timer_in = '0; done_in = 1'b1;
               end
               default: begin
                  phase_in = PH_IDLE; timer_in = '0; done_in = 1'b1;
               end
            endcase
         end
      end else begin
         case (in_word.cmd)
            CMD_START: begin
               phase_in = PH_START_HOLD; scl_in = 1'b1; sda_low_in = 1'b0;
               timer_in = timer_load(u_eff, 1'b1);
            end
            CMD_STOP: begin
               phase_in = PH_STOP_SCL_LOW; scl_in = 1'b0;
               timer_in = timer_load(u_eff, 1'b0);
            end
            CMD_WRITE: begin
               shifter_in   = in_word.tx_byte;
               bit_count_in = '0;
               phase_in     = PH_WR_SETUP; scl_in = 1'b0;
               timer_in     = timer_load(u_eff, 1'b1);
            end
            CMD_READ: begin
               shifter_in   = '0;
               bit_count_in = '0;
               ack_req_in   = in_word.send_ack;
               phase_in     = PH_RD_LOW; scl_in = 1'b0; sda_low_in = 1'b0;
               timer_in     = timer_load(u_eff, 1'b0);
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= '0;
         shifter_ff   <= '0;
         timer_ff     <= '0;
         scl_ff       <= 1'b1;
         sda_low_ff   <= 1'b0;
         ack_flag_ff  <= 1'b0;
         ack_req_ff   <= 1'b0;
         rx_hold_ff   <= '0;
         done_ff      <= 1'b0;
         rej_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         phase_ff     <= phase_in;
         bit_count_ff <= bit_count_in;
         shifter_ff   <= shifter_in;
         timer_ff     <= timer_in;
         scl_ff       <= scl_in;
         sda_low_ff   <= sda_low_in;
         ack_flag_ff  <= ack_flag_in;
         ack_req_ff   <= ack_req_in;
         rx_hold_ff   <= rx_hold_in;
         done_ff      <= done_in;
         rej_ff       <= rej_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_word.scl_level    = scl_ff;
   assign rsp_word.sda_pull_low = sda_low_ff;
   assign rsp_word.busy_res     = (phase_ff != PH_IDLE);
   assign rsp_word.done_res     = done_ff;
   assign rsp_word.rx_byte      = rx_hold_ff;
   assign rsp_word.slave_acked  = ack_flag_ff;
   assign rsp_word.rejected     = rej_ff;

endmodule
